// File: rtl/scr_pkg.sv
// Shared widths, constants and the classified request record for the segment collision block.
package scr_pkg;

  localparam int CRD_W   = 24;            // input coordinate, Q15.8
  localparam int DIF_W   = CRD_W + 1;     // difference of two points
  localparam int PRD_W   = 2 * DIF_W;     // product of two differences
  localparam int SUM_W   = PRD_W + 1;     // sum of two products
  localparam int NUM_W   = SUM_W + 1;     // distance numerator
  localparam int LEN_W   = 25;            // root of a squared length
  localparam int SQ_W    = 2 * LEN_W;     // squared length
  localparam int MAG_W   = DIF_W;         // magnitude of a direction component
  localparam int UNIT_SHIFT = 14;         // Q1.14 scale
  localparam int UQ_W    = UNIT_SHIFT + 1;
  localparam int UDV_W   = MAG_W + UNIT_SHIFT;
  localparam int DQ_W    = 25;            // distance quotient bits
  localparam int TOL_W   = 16;
  localparam int PUSH_W  = 16;
  localparam int DIST_W  = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Classified request handed from the front part to the back part
  typedef struct packed {
    logic               collide;
    logic               xneg;
    logic               yneg;
    logic [MAG_W-1:0]   xmag;
    logic [MAG_W-1:0]   ymag;
    logic [SQ_W-1:0]    sq;
    logic [NUM_W-1:0]   num;
  } scr_item_t;

endpackage

// File: rtl/scr_in_if.sv
// Request channel carrying the end points of both segments.
interface scr_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] ax;
  logic signed [23:0] ay;
  logic signed [23:0] bx;
  logic signed [23:0] by;
  logic signed [23:0] cx;
  logic signed [23:0] cy;
  logic signed [23:0] dx;
  logic signed [23:0] dy;
  modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

// File: rtl/scr_out_if.sv
// Result channel carrying the collision flag and push vector.
interface scr_out_if;
  logic               valid;
  logic               ready;
  logic               collide;
  logic signed [15:0] push_x;
  logic signed [15:0] push_y;
  logic [24:0]        push_distance;
  modport source (output valid, collide, push_x, push_y, push_distance, input ready);
  modport sink   (input valid, collide, push_x, push_y, push_distance, output ready);
endinterface

// File: rtl/scr_cfg_if.sv
// Configuration write channel for the parallel tolerance register.
interface scr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/scr_front.sv
// Front part: accepts segment pairs, forms cross and dot products and classifies them.
module scr_front import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  scr_in_if.sink    pairs,
  scr_cfg_if.sink   cfg,
  output logic      item_valid,
  output scr_item_t item,
  input  logic      item_ready
);

  logic [TOL_W-1:0] tol;
  logic [4:0]       v;
  logic             en;

  // stage 1: input registers
  logic signed [CRD_W-1:0] ax1, ay1, bx1, by1, cx1, cy1, dx1, dy1;
  // stage 2: differences
  logic signed [DIF_W-1:0] rx2, ry2, sx2, sy2, qx2, qy2, wx2, wy2;
  // stage 3: products
  logic signed [PRD_W-1:0] rs1, rs2, qr1, qr2, qs1, qs2, rr1, rr2, ss1, ss2;
  logic signed [PRD_W-1:0] b01, b02, b11, b12;
  logic signed [DIF_W-1:0] rx3, ry3, sx3, sy3;
  // stage 4: sums
  logic signed [SUM_W-1:0] den4, un4, tn4, l2r4, l2s4, b04, b14;
  logic signed [NUM_W-1:0] pb4;
  logic signed [DIF_W-1:0] rx4, ry4, sx4, sy4;
  // stage 5: sign tests and magnitudes
  logic                    den_small5, un_small5, l2zero5, inside5;
  logic signed [SUM_W-1:0] bmin5, bmax5, l2r5, l2s5;
  logic [NUM_W-1:0]        pa_mag5, pb_mag5;
  logic                    pa_neg5, pb_neg5;
  logic [MAG_W-1:0]        rxm5, rym5, sxm5, sym5;
  logic                    rx_neg5, ry_neg5, sx_neg5, sy_pos5;

  logic signed [SUM_W-1:0] tolv;
  logic                    inside_c;
  logic                    c_hit, c_back, sel_a, p_neg, neg;
  logic [NUM_W-1:0]        c_num;
  scr_item_t               item_c;

  assign cfg.ready   = 1'b1;
  assign en          = !item_valid || item_ready;
  assign pairs.ready = en;
  assign tolv        = SUM_W'($signed({1'b0, tol}));

  // hold the tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg.valid) begin
      tol <= cfg.data;
    end
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      item_valid <= 1'b0;
    end else if (en) begin
      v          <= {v[3:0], pairs.valid};
      item_valid <= v[4];
    end
  end

  // stage 1 to 4: registers, differences, products, sums
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= pairs.ax; ay1 <= pairs.ay; bx1 <= pairs.bx; by1 <= pairs.by;
      cx1 <= pairs.cx; cy1 <= pairs.cy; dx1 <= pairs.dx; dy1 <= pairs.dy;

      rx2 <= DIF_W'(bx1) - DIF_W'(ax1);
      ry2 <= DIF_W'(by1) - DIF_W'(ay1);
      sx2 <= DIF_W'(dx1) - DIF_W'(cx1);
      sy2 <= DIF_W'(dy1) - DIF_W'(cy1);
      qx2 <= DIF_W'(cx1) - DIF_W'(ax1);
      qy2 <= DIF_W'(cy1) - DIF_W'(ay1);
      wx2 <= DIF_W'(dx1) - DIF_W'(ax1);
      wy2 <= DIF_W'(dy1) - DIF_W'(ay1);

      rs1 <= rx2 * sy2; rs2 <= ry2 * sx2;
      qr1 <= qx2 * ry2; qr2 <= qy2 * rx2;
      qs1 <= qx2 * sy2; qs2 <= qy2 * sx2;
      rr1 <= rx2 * rx2; rr2 <= ry2 * ry2;
      ss1 <= sx2 * sx2; ss2 <= sy2 * sy2;
      b01 <= qx2 * rx2; b02 <= qy2 * ry2;
      b11 <= wx2 * rx2; b12 <= wy2 * ry2;
      rx3 <= rx2; ry3 <= ry2; sx3 <= sx2; sy3 <= sy2;

      den4 <= SUM_W'(rs1) - SUM_W'(rs2);
      un4  <= SUM_W'(qr1) - SUM_W'(qr2);
      tn4  <= SUM_W'(qs1) - SUM_W'(qs2);
      l2r4 <= SUM_W'(rr1) + SUM_W'(rr2);
      l2s4 <= SUM_W'(ss1) + SUM_W'(ss2);
      b04  <= SUM_W'(b01) + SUM_W'(b02);
      b14  <= SUM_W'(b11) + SUM_W'(b12);
      // distance of B from CD's line equals tn minus the cross product
      pb4  <= NUM_W'(qs1) - NUM_W'(qs2) - NUM_W'(rs1) + NUM_W'(rs2);
      rx4 <= rx3; ry4 <= ry3; sx4 <= sx3; sy4 <= sy3;
    end
  end

  // crossing test by signs
  always_comb begin
    if (den4 > 0) begin
      inside_c = (tn4 >= 0) && (tn4 <= den4) && (un4 >= 0) && (un4 <= den4);
    end else begin
      inside_c = (tn4 <= 0) && (tn4 >= den4) && (un4 <= 0) && (un4 >= den4);
    end
  end

  // stage 5: tolerance tests, ordering and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      den_small5 <= (den4 <= tolv) && (den4 >= -tolv);
      un_small5  <= (un4 <= tolv) && (un4 >= -tolv);
      l2zero5    <= (l2r4 == '0);
      inside5    <= inside_c;
      bmin5      <= (b04 < b14) ? b04 : b14;
      bmax5      <= (b04 < b14) ? b14 : b04;
      l2r5       <= l2r4;
      l2s5       <= l2s4;
      pa_mag5    <= NUM_W'(tn4[SUM_W-1] ? -tn4 : tn4);
      pb_mag5    <= pb4[NUM_W-1] ? NUM_W'(-pb4) : NUM_W'(pb4);
      pa_neg5    <= tn4[SUM_W-1];
      pb_neg5    <= pb4[NUM_W-1];
      rxm5       <= rx4[DIF_W-1] ? MAG_W'(-rx4) : MAG_W'(rx4);
      rym5       <= ry4[DIF_W-1] ? MAG_W'(-ry4) : MAG_W'(ry4);
      sxm5       <= sx4[DIF_W-1] ? MAG_W'(-sx4) : MAG_W'(sx4);
      sym5       <= sy4[DIF_W-1] ? MAG_W'(-sy4) : MAG_W'(sy4);
      rx_neg5    <= rx4[DIF_W-1];
      ry_neg5    <= ry4[DIF_W-1];
      sx_neg5    <= sx4[DIF_W-1];
      sy_pos5    <= !sy4[DIF_W-1] && (sy4 != '0);
    end
  end

  // stage 6: pick the collinear or crossing answer
  always_comb begin
    c_hit  = !(bmin5 >= l2r5) && !(bmax5 <= 0);
    c_back = (l2r5 <= bmax5);
    c_num  = c_back ? NUM_W'(NUM_W'(l2r5) - NUM_W'(bmin5)) : NUM_W'(bmax5);
    sel_a  = (pa_mag5 <= pb_mag5);
    p_neg  = sel_a ? pa_neg5 : pb_neg5;
    item_c = '0;
    if (den_small5) begin
      neg            = c_back;
      item_c.collide = un_small5 && !l2zero5 && c_hit;
      item_c.xneg    = rx_neg5 ^ neg;
      item_c.yneg    = ry_neg5 ^ neg;
      item_c.xmag    = rxm5;
      item_c.ymag    = rym5;
      item_c.sq      = SQ_W'(l2r5);
      item_c.num     = c_num;
    end else begin
      // push along the normal (-sy, sx), away from the nearer end point
      neg            = !p_neg;
      item_c.collide = inside5;
      item_c.xneg    = sy_pos5 ^ neg;
      item_c.yneg    = sx_neg5 ^ neg;
      item_c.xmag    = sym5;
      item_c.ymag    = sxm5;
      item_c.sq      = SQ_W'(l2s5);
      item_c.num     = sel_a ? pa_mag5 : pb_mag5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_c;
    end
  end

endmodule

// File: rtl/scr_queue.sv
// Short queue between the front and back parts.
module scr_queue import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  scr_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output scr_item_t pop_item,
  input  logic      pop_ready
);

  scr_item_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/scr_back.sv
// Back part: pipelined square root and dividers that turn a classified request into a result.
module scr_back import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  scr_item_t item,
  output logic      item_ready,
  scr_out_if.source results
);

  typedef struct packed {
    scr_item_t          it;
    logic [LEN_W-1:0]   root;
    logic [LEN_W+1:0]   rem;
  } sq_stage_t;

  typedef struct packed {
    logic               collide;
    logic               xneg;
    logic               yneg;
    logic               sat;
    logic [LEN_W-1:0]   len;
    logic [DQ_W-1:0]    num_lo;
    logic [MAG_W-1:0]   xmag;
    logic [MAG_W-1:0]   ymag;
    logic [LEN_W-1:0]   rd;
    logic [LEN_W-1:0]   rxr;
    logic [LEN_W-1:0]   ryr;
    logic [DQ_W-1:0]    qd;
    logic [UQ_W-1:0]    qx;
    logic [UQ_W-1:0]    qy;
  } dv_stage_t;

  sq_stage_t          sq_r [LEN_W];
  logic [LEN_W-1:0]   sq_v;
  dv_stage_t          dv_r [DQ_W+1];
  logic [DQ_W:0]      dv_v;
  logic               en;

  assign en         = !results.valid || results.ready;
  assign item_ready = en;

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v          <= '0;
      dv_v          <= '0;
      results.valid <= 1'b0;
    end else if (en) begin
      sq_v          <= {sq_v[LEN_W-2:0], item_valid};
      dv_v          <= {dv_v[DQ_W-1:0], sq_v[LEN_W-1]};
      results.valid <= dv_v[DQ_W];
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < LEN_W; i++) begin : g_sqrt
    sq_stage_t        prev;
    logic [LEN_W+3:0] t;
    logic [LEN_W+3:0] trial;
    if (i == 0) begin : g_first
      assign prev = '{it: item, root: '0, rem: '0};
    end else begin : g_rest
      assign prev = sq_r[i-1];
    end
    assign t     = {prev.rem, prev.it.sq[SQ_W-1-2*i -: 2]};
    assign trial = (LEN_W+4)'({prev.root, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i].it <= prev.it;
        if (t >= trial) begin
          sq_r[i].rem  <= (LEN_W+2)'(t - trial);
          sq_r[i].root <= {prev.root[LEN_W-2:0], 1'b1};
        end else begin
          sq_r[i].rem  <= (LEN_W+2)'(t);
          sq_r[i].root <= {prev.root[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  // set up the dividers and detect distance overflow
  logic [UDV_W-1:0] x_div0, y_div0;
  assign x_div0 = {sq_r[LEN_W-1].it.xmag, UNIT_SHIFT'(0)};
  assign y_div0 = {sq_r[LEN_W-1].it.ymag, UNIT_SHIFT'(0)};

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].collide <= sq_r[LEN_W-1].it.collide;
      dv_r[0].xneg    <= sq_r[LEN_W-1].it.xneg;
      dv_r[0].yneg    <= sq_r[LEN_W-1].it.yneg;
      dv_r[0].sat     <= (sq_r[LEN_W-1].it.num[NUM_W-1:DQ_W] >=
                          (NUM_W-DQ_W)'(sq_r[LEN_W-1].root));
      dv_r[0].len     <= sq_r[LEN_W-1].root;
      dv_r[0].num_lo  <= sq_r[LEN_W-1].it.num[DQ_W-1:0];
      dv_r[0].xmag    <= sq_r[LEN_W-1].it.xmag;
      dv_r[0].ymag    <= sq_r[LEN_W-1].it.ymag;
      dv_r[0].rd      <= sq_r[LEN_W-1].it.num[DQ_W+LEN_W-1:DQ_W];
      dv_r[0].rxr     <= LEN_W'(x_div0 >> UQ_W);
      dv_r[0].ryr     <= LEN_W'(y_div0 >> UQ_W);
      dv_r[0].qd      <= '0;
      dv_r[0].qx      <= '0;
      dv_r[0].qy      <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DQ_W; j++) begin : g_div
    dv_stage_t        p;
    dv_stage_t        n;
    logic [LEN_W:0]   td, tx, ty;
    logic [UDV_W-1:0] xdv, ydv;
    assign p   = dv_r[j];
    assign xdv = {p.xmag, UNIT_SHIFT'(0)};
    assign ydv = {p.ymag, UNIT_SHIFT'(0)};
    assign td  = {p.rd, p.num_lo[DQ_W-1-j]};
    if (j < UQ_W) begin : g_unit
      assign tx = {p.rxr, xdv[UQ_W-1-j]};
      assign ty = {p.ryr, ydv[UQ_W-1-j]};
    end else begin : g_idle
      assign tx = {p.rxr, 1'b0};
      assign ty = {p.ryr, 1'b0};
    end
    always_comb begin
      n = p;
      if (td >= {1'b0, p.len}) begin
        n.rd = LEN_W'(td - {1'b0, p.len});
        n.qd = {p.qd[DQ_W-2:0], 1'b1};
      end else begin
        n.rd = LEN_W'(td);
        n.qd = {p.qd[DQ_W-2:0], 1'b0};
      end
      if (j < UQ_W) begin
        if (tx >= {1'b0, p.len}) begin
          n.rxr = LEN_W'(tx - {1'b0, p.len});
          n.qx  = {p.qx[UQ_W-2:0], 1'b1};
        end else begin
          n.rxr = LEN_W'(tx);
          n.qx  = {p.qx[UQ_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, p.len}) begin
          n.ryr = LEN_W'(ty - {1'b0, p.len});
          n.qy  = {p.qy[UQ_W-2:0], 1'b1};
        end else begin
          n.ryr = LEN_W'(ty);
          n.qy  = {p.qy[UQ_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1] <= n;
      end
    end
  end

  // apply signs, saturate and zero the result when there is no collision
  logic [PUSH_W-1:0] ux_m, uy_m;
  dv_stage_t         f;
  assign f    = dv_r[DQ_W];
  assign ux_m = PUSH_W'(f.qx);
  assign uy_m = PUSH_W'(f.qy);

  always_ff @(posedge clk) begin
    if (en) begin
      results.collide <= f.collide;
      if (f.collide) begin
        results.push_x        <= f.xneg ? -ux_m : ux_m;
        results.push_y        <= f.yneg ? -uy_m : uy_m;
        results.push_distance <= f.sat ? DIST_MAX : DIST_W'(f.qd);
      end else begin
        results.push_x        <= '0;
        results.push_y        <= '0;
        results.push_distance <= '0;
      end
    end
  end

endmodule

// File: rtl/segment_collision_resolve.sv
// Throughput: one segment pair per cycle while the queue has room; the back part is a
// 25 stage square root followed by a 25 stage restoring divider, one bit per stage.
// Reset: synchronous, clears all valid bits and the queue; tolerance resets to 0.
// A waiting result stalls the back part; the queue lets the front keep taking requests
// until it fills.
module segment_collision_resolve import scr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  scr_in_if.sink     pairs,
  scr_cfg_if.sink    cfg,
  scr_out_if.source  results
);

  logic      f_valid, f_ready;
  scr_item_t f_item;
  logic      b_valid, b_ready;
  scr_item_t b_item;

  scr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pairs      (pairs),
    .cfg        (cfg),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  scr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_item   (b_item),
    .pop_ready  (b_ready)
  );

  scr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item       (b_item),
    .item_ready (b_ready),
    .results    (results)
  );

  // front stalls only when its last stage is blocked by a full queue
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !pairs.ready |-> (f_valid && !f_ready))
    else $error("front stalled without a full queue");

  // back stalls only when the result waits
  a_back_stall: assert property (@(posedge clk) disable iff (rst)
    !b_ready |-> (results.valid && !results.ready))
    else $error("back stalled without a waiting result");

  // no collision gives an all-zero result
  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.collide) |->
      (results.push_x == 0 && results.push_y == 0 && results.push_distance == 0))
    else $error("non-zero push without collision");

  // push components stay within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.collide) |->
      (results.push_x <= 16'sd16384 && results.push_x >= -16'sd16384 &&
       results.push_y <= 16'sd16384 && results.push_y >= -16'sd16384))
    else $error("push component out of unit range");

endmodule
